>>> src/bffpa_pkg.sv
// ============================================================================
// bffpa_pkg : shared types and constants of the bitmap page frame allocator
// Field widths, action codes, beat structs and parameter defaults.
// ============================================================================
package bffpa_pkg;

    localparam int ACT_W  = 2;
    localparam int PIDX_W = 15;
    localparam int ADDR_W = 32;

    localparam int DEF_BITMAP_WORDS = 1024 * 3 / 4;
    localparam int DEF_WORD_BITS    = 32;
    localparam int DEF_PAGE_SHIFT   = 12;

    typedef logic [ACT_W-1:0] t_action;

    localparam t_action ACT_ALLOC     = 2'd0;
    localparam t_action ACT_MARK_USED = 2'd1;
    localparam t_action ACT_MARK_FREE = 2'd2;

    typedef struct packed {
        t_action           action;
        logic [PIDX_W-1:0] page_index;
    } t_alloc_req;

    typedef struct packed {
        logic              success;
        logic [PIDX_W-1:0] granted_index;
        logic [ADDR_W-1:0] granted_address;
    } t_alloc_rsp;

endpackage

>>> src/bitmap_first_fit_page_allocator.sv
// ============================================================================
// bitmap_first_fit_page_allocator : first-fit bitmap page frame allocator
// One usage bit per page frame, held in a single-port synchronous memory.
// ============================================================================
// Using the block: after reset the bitmap memory is swept to zero, one word
// per cycle; busy stays high throughout.
// A beat is taken when start is high and busy is low, and exactly one result
// beat follows on o_done/o_rsp, which the receiver must take as it comes.
// An allocate reads one bitmap word per cycle, starting at the lowest word
// that may still hold a free page, and passes over every full word until a
// free page turns up.
// An allocate on a full bitmap, once this is known, fails without a memory
// read. A mark (used or free) runs through word index, memory read and write
// back. An out-of-range mark or an undefined action fails without touching
// the bitmap.
// The base address register may be written only while the block is idle.
// ============================================================================
module bitmap_first_fit_page_allocator #(
    parameter int BITMAP_WORDS = bffpa_pkg::DEF_BITMAP_WORDS,
    parameter int WORD_BITS    = bffpa_pkg::DEF_WORD_BITS,
    parameter int PAGE_SHIFT   = bffpa_pkg::DEF_PAGE_SHIFT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  bffpa_pkg::t_alloc_req               i_req,
    output logic                                o_done,
    output bffpa_pkg::t_alloc_rsp               o_rsp,
    input  logic                                i_cfg_we,
    input  logic [bffpa_pkg::ADDR_W-1:0]        i_cfg_wdata
);
    import bffpa_pkg::*;

    // Word address, hint (may equal BITMAP_WORDS to mean "all full"),
    // bit position and page index widths.
    localparam int AW    = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int HW    = $clog2(BITMAP_WORDS + 1);
    localparam int BW    = $clog2(WORD_BITS);
    localparam int TOTAL = BITMAP_WORDS * WORD_BITS;
    localparam int IW    = $clog2(TOTAL);

    // Word index of a page by reciprocal multiplication, exact for every
    // PIDX_W-bit page number.
    localparam int DIV_SH = PIDX_W + BW;
    localparam longint DIV_M_VAL =
        ((longint'(1) << DIV_SH) + longint'(WORD_BITS) - 1) / longint'(WORD_BITS);
    localparam logic [DIV_SH:0] DIV_M = (DIV_SH + 1)'(DIV_M_VAL);
    localparam int PW = PIDX_W + DIV_SH + 1;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_QUOT  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_MARK  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_cur, n_cur;
    logic [HW-1:0]       r_hint, n_hint;
    logic [ADDR_W-1:0]   r_base;
    t_action             r_action, n_action;
    logic [PIDX_W-1:0]   r_page, n_page;
    logic                r_done, n_done;
    t_alloc_rsp          r_rsp, n_rsp;

    // Bitmap memory and its registered read port.
    logic [WORD_BITS-1:0] mem [BITMAP_WORDS];
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;

    logic [PW-1:0]        quot_prod;
    logic [AW-1:0]        quot;
    logic                 word_open;
    logic [BW-1:0]        zero_bit;
    logic [IW-1:0]        word_first;
    logic [IW-1:0]        alloc_idx;
    logic [BW-1:0]        mark_bit;
    logic                 in_range;
    logic                 take;

    assign busy   = (r_state != S_IDLE);
    assign take   = start && !busy;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    assign in_range = (32'(i_req.page_index) < 32'(TOTAL));

    assign quot_prod = PW'(r_page) * PW'(DIV_M);
    assign quot      = AW'(quot_prod >> DIV_SH);

    // Lowest clear bit of the word just read.
    assign word_open = ~&r_rd_data;
    always_comb begin
        zero_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!r_rd_data[i]) begin
                zero_bit = BW'(i);
            end
        end
    end

    assign word_first = IW'(r_cur) * IW'(WORD_BITS);
    assign alloc_idx  = word_first + IW'(zero_bit);
    assign mark_bit   = BW'(IW'(r_page) - word_first);

    always_comb begin
        n_state  = r_state;
        n_cur    = r_cur;
        n_hint   = r_hint;
        n_action = r_action;
        n_page   = r_page;
        n_done   = 1'b0;
        n_rsp    = r_rsp;
        rd_en    = 1'b0;
        rd_addr  = r_cur;
        wr_en    = 1'b0;
        wr_data  = '0;

        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                if (r_cur == AW'(BITMAP_WORDS - 1)) begin
                    n_cur   = '0;
                    n_hint  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cur = r_cur + AW'(1);
                end
            end
            S_IDLE: begin
                if (take) begin
                    n_action = i_req.action;
                    n_page   = i_req.page_index;
                    // Fail answer by default; overwritten when work goes on.
                    n_rsp    = '0;
                    priority if (i_req.action == ACT_ALLOC) begin
                        if (r_hint == HW'(BITMAP_WORDS)) begin
                            n_done = 1'b1;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = AW'(r_hint);
                            n_cur   = AW'(r_hint);
                            n_state = S_SCAN;
                        end
                    end else if ((i_req.action == ACT_MARK_USED ||
                                  i_req.action == ACT_MARK_FREE) && in_range) begin
                        n_state = S_QUOT;
                    end else begin
                        n_done = 1'b1;
                    end
                end
            end
            S_QUOT: begin
                rd_en   = 1'b1;
                rd_addr = quot;
                n_cur   = quot;
                n_state = S_MARK;
            end
            S_SCAN: begin
                if (word_open) begin
                    wr_en   = 1'b1;
                    wr_data = r_rd_data | (WORD_BITS'(1) << zero_bit);
                    n_hint  = HW'(r_cur);
                    n_done  = 1'b1;
                    n_rsp.success         = 1'b1;
                    n_rsp.granted_index   = PIDX_W'(alloc_idx);
                    n_rsp.granted_address =
                        r_base + (ADDR_W'(alloc_idx) << PAGE_SHIFT);
                    n_state = S_IDLE;
                end else if (r_cur == AW'(BITMAP_WORDS - 1)) begin
                    n_hint  = HW'(BITMAP_WORDS);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_cur + AW'(1);
                    n_cur   = r_cur + AW'(1);
                end
            end
            S_MARK: begin
                wr_en = 1'b1;
                if (r_action == ACT_MARK_USED) begin
                    wr_data = r_rd_data | (WORD_BITS'(1) << mark_bit);
                end else begin
                    wr_data = r_rd_data & ~(WORD_BITS'(1) << mark_bit);
                    // A freed page below the hint becomes the new scan start.
                    if (HW'(r_cur) < r_hint) begin
                        n_hint = HW'(r_cur);
                    end
                end
                n_done        = 1'b1;
                n_rsp.success = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_cur] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cur   <= '0;
            r_hint  <= '0;
            r_base  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_hint  <= n_hint;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_page   <= n_page;
        r_rsp    <= n_rsp;
    end

    // The hint never points past the end of the bitmap.
    a_hint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hint <= HW'(BITMAP_WORDS))
        else $error("scan hint beyond bitmap");

    // A scan never looks below the word it started from.
    a_scan_above_hint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (HW'(r_cur) >= r_hint))
        else $error("scan below hint");

    // No result beat while the memory is still being cleared.
    a_no_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_done)
        else $error("result during clearing pass");

    // The block only leaves idle because a beat was taken.
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_IDLE && busy) |-> $past(start))
        else $error("busy without start");

    // A failed or mark result carries no page.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_rsp.success) |->
        (o_rsp.granted_index == '0 && o_rsp.granted_address == '0))
        else $error("failed result with page data");

endmodule

>>> tb/sv/page_grant_monitor.sv
// ============================================================================
// page_grant_monitor : result checker for the bitmap page frame allocator
// Watches the request, result and register channels, keeps its own copy of
// the usage bitmap and base address, and compares every result beat with
// the oldest outstanding prediction.
// ============================================================================
module page_grant_monitor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  bffpa_pkg::t_alloc_req         i_req,
    input  logic                          i_done,
    input  bffpa_pkg::t_alloc_rsp         i_rsp,
    input  logic                          i_cfg_we,
    input  logic [bffpa_pkg::ADDR_W-1:0]  i_cfg_wdata,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_grants,
    output int                            o_refusals,
    output int                            o_marks,
    output int                            o_rejects
);
    import bffpa_pkg::*;

    localparam int WORDS        = DEF_BITMAP_WORDS;
    localparam int WBITS        = DEF_WORD_BITS;
    localparam int TOTAL_PAGES  = WORDS * WBITS;
    localparam int REPORT_LIMIT = 10;

    logic [WBITS-1:0]  usage_words [WORDS];
    logic [ADDR_W-1:0] frame_base;
    t_alloc_rsp        grant_q [$];

    task automatic log_fault(input string msg);
        o_fail_count++;
        if (o_fail_count <= REPORT_LIMIT) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    // First fit: lowest clear bit of the lowest word that is not all ones.
    function automatic t_alloc_rsp predict_outcome(input t_alloc_req req);
        t_alloc_rsp        rsp;
        int                idx;
        int                page;
        bit                found;
        logic [ADDR_W-1:0] offset;
        rsp   = '0;
        idx   = 0;
        found = 1'b0;
        page  = int'(req.page_index);
        case (req.action)
            ACT_ALLOC: begin
                for (int w = 0; w < WORDS && !found; w++) begin
                    if (usage_words[w] != '1) begin
                        for (int b = 0; b < WBITS && !found; b++) begin
                            if (!usage_words[w][b]) begin
                                usage_words[w][b] = 1'b1;
                                idx   = w * WBITS + b;
                                found = 1'b1;
                            end
                        end
                    end
                end
                if (found) begin
                    offset                = idx;
                    offset                = offset << DEF_PAGE_SHIFT;
                    rsp.success           = 1'b1;
                    rsp.granted_index     = idx[PIDX_W-1:0];
                    rsp.granted_address   = frame_base + offset;
                end
            end
            ACT_MARK_USED, ACT_MARK_FREE: begin
                if (page < TOTAL_PAGES) begin
                    usage_words[page / WBITS][page % WBITS] = (req.action == ACT_MARK_USED);
                    rsp.success = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_alloc_rsp want;
        if (!i_rst_n) begin
            for (int w = 0; w < WORDS; w++) begin
                usage_words[w] = '0;
            end
            frame_base = '0;
            grant_q.delete();
        end else begin
            if (i_done === 1'b1) begin
                if (grant_q.size() == 0) begin
                    log_fault($sformatf("result beat with nothing outstanding: %b/%0d/%h",
                                        i_rsp.success, i_rsp.granted_index,
                                        i_rsp.granted_address));
                end else begin
                    want = grant_q.pop_front();
                    if (i_rsp.success !== want.success
                            || i_rsp.granted_index !== want.granted_index
                            || i_rsp.granted_address !== want.granted_address) begin
                        log_fault($sformatf({"mismatch: expected success=%b index=%0d ",
                                             "addr=%h, got success=%b index=%0d addr=%h"},
                                            want.success, want.granted_index,
                                            want.granted_address, i_rsp.success,
                                            i_rsp.granted_index, i_rsp.granted_address));
                    end
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                want = predict_outcome(i_req);
                grant_q.push_back(want);
                if (i_req.action == ACT_ALLOC) begin
                    if (want.success) o_grants++;
                    else o_refusals++;
                end else if (want.success) begin
                    o_marks++;
                end else begin
                    o_rejects++;
                end
            end
            if (i_cfg_we === 1'b1) begin
                frame_base = i_cfg_wdata;
            end
        end
        o_pending = grant_q.size();
    end

endmodule

>>> tb/sv/bitmap_first_fit_page_allocator_test.sv
// ============================================================================
// bitmap_first_fit_page_allocator_test : top of the page allocator testbench
// Drives request beats and base address writes into the allocator, with a
// monitor alongside that predicts and checks every result beat.
// ============================================================================
// The run has two parts. A short directed part touches the extremes of the
// page index, every action including the undefined one, marks that find the
// page already in the wanted state and marks beyond the end of the bitmap.
// Three random segments follow, each under a different base address, mixing
// allocations with frees and marks so that the bitmap stays fragmented and
// the allocator has to scan over runs of full words.
// ============================================================================
module bitmap_first_fit_page_allocator_test;
    import bffpa_pkg::*;

    localparam int TOTAL_PAGES    = DEF_BITMAP_WORDS * DEF_WORD_BITS;
    // Longest honest silence is the clearing sweep after reset or a scan over
    // the whole bitmap, and the limit is set well above both.
    localparam int STALL_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = DEF_BITMAP_WORDS + 32;
    localparam int SEGMENT_BEATS  = 140;
    localparam t_action ACT_UNDEFINED = 2'd3;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    t_alloc_req        i_req       = '0;
    logic              o_done;
    t_alloc_rsp        o_rsp;
    logic              i_cfg_we    = 1'b0;
    logic [ADDR_W-1:0] i_cfg_wdata = '0;

    int fail_count;
    int pending_beats;
    int grants;
    int refusals;
    int marks;
    int rejects;
    int stall_cycles = 0;
    int burst_left   = 0;
    int beats_sent   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bitmap_first_fit_page_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    page_grant_monitor monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_done       (o_done),
        .i_rsp        (o_rsp),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_beats),
        .o_grants     (grants),
        .o_refusals   (refusals),
        .o_marks      (marks),
        .o_rejects    (rejects)
    );

    // Watchdog: any edge at which a request or a result beat moves counts as
    // progress. The values read here are those from before the edge.
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic t_alloc_req make_beat(input t_action act, input int page);
        t_alloc_req beat;
        beat.action     = act;
        beat.page_index = page[PIDX_W-1:0];
        return beat;
    endfunction

    // Mostly pages in the first 64 words, so frees and allocations meet.
    function automatic int pick_page();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2047);
        return $urandom_range(0, TOTAL_PAGES - 1);
    endfunction

    function automatic t_alloc_req random_beat();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) return make_beat(ACT_ALLOC, $urandom_range(0, 32767));
        if (pick < 65) return make_beat(ACT_MARK_FREE, pick_page());
        if (pick < 85) return make_beat(ACT_MARK_USED, pick_page());
        if (pick < 95) begin
            // Beyond the last page: rejected without touching the bitmap.
            return make_beat($urandom_range(0, 1) ? ACT_MARK_USED : ACT_MARK_FREE,
                             $urandom_range(TOTAL_PAGES, 32767));
        end
        return make_beat(ACT_UNDEFINED, $urandom_range(0, 32767));
    endfunction

    // Present one request beat and return at the edge that accepts it. Before
    // it the sender may idle with start low, except inside a burst where
    // start stays high from one beat to the next without a break.
    task automatic send_beat(input t_alloc_req beat);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 5);
            if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(10, 60);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= beat;
        // busy only moves on a rising edge, so at the falling edge it is
        // settled: once it reads low there, the next rising edge takes the beat.
        @(negedge i_clk);
        while (busy !== 1'b0) @(negedge i_clk);
        @(posedge i_clk);
        beats_sent++;
    endtask

    // Stop sending and hold off until every predicted result has arrived and
    // the allocator reports itself free again.
    task automatic wait_idle();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending_beats != 0 || busy !== 1'b0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_base(input logic [ADDR_W-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The first two allocations run with the base address
        // still at its reset value; the page field is ignored for allocate.
        send_beat(make_beat(ACT_ALLOC, 32767));
        send_beat(make_beat(ACT_ALLOC, 0));
        // Top of the address range: any grant above page 0 wraps round 2^32.
        write_base(32'hFFFF_FFFF);
        send_beat(make_beat(ACT_ALLOC, 0));
        send_beat(make_beat(ACT_MARK_USED, 0));            // already used
        send_beat(make_beat(ACT_MARK_FREE, 0));
        send_beat(make_beat(ACT_MARK_FREE, 0));            // already free
        send_beat(make_beat(ACT_ALLOC, 0));                // takes page 0 back
        send_beat(make_beat(ACT_MARK_USED, 5));
        send_beat(make_beat(ACT_ALLOC, 0));
        send_beat(make_beat(ACT_ALLOC, 0));
        send_beat(make_beat(ACT_ALLOC, 0));                // skips page 5
        send_beat(make_beat(ACT_MARK_USED, TOTAL_PAGES - 1));
        send_beat(make_beat(ACT_MARK_FREE, TOTAL_PAGES - 1));
        send_beat(make_beat(ACT_MARK_USED, TOTAL_PAGES));  // first page past the end
        send_beat(make_beat(ACT_MARK_FREE, 32767));
        send_beat(make_beat(ACT_MARK_USED, 32767));
        send_beat(make_beat(ACT_UNDEFINED, 0));
        send_beat(make_beat(ACT_UNDEFINED, 32767));
        send_beat(make_beat(ACT_MARK_USED, 15'h2AAA));
        send_beat(make_beat(ACT_MARK_FREE, 15'h5555));
        send_beat(make_beat(ACT_ALLOC, 15'h5555));

        // Random segments, each under its own base address. Now and then the
        // sender waits for the allocator to drain before carrying on.
        for (int seg = 0; seg < 3; seg++) begin
            case (seg)
                0:       write_base($urandom);
                1:       write_base(32'hFFFF_F000);
                default: write_base($urandom);
            endcase
            repeat (SEGMENT_BEATS) begin
                if ($urandom_range(0, 39) == 0) wait_idle();
                send_beat(random_beat());
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d request beats: %0d pages granted, %0d refused on a full bitmap,",
                 beats_sent, grants, refusals);
        $display("%0d marks applied and %0d rejected, under five base address settings.",
                 marks, rejects);
        if (fail_count == 0 && pending_beats == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
